// File: rtl/person_target_lock_defines.svh
// Assertion macros shared by the target lock RTL.
// Included by modules that check their own invariants; no other dependencies.
`ifndef PERSON_TARGET_LOCK_DEFINES_SVH
`define PERSON_TARGET_LOCK_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define PTL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, idle during reset.
`define PTL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ptl_pkg.sv
// Shared types, constants and width helpers for the target lock block.
// No dependencies; used by every module under rtl.
package ptl_pkg;

    localparam int ID_BITS      = 32;
    localparam int LIMB_BITS    = 4;
    localparam int MARGIN_BITS  = 13;
    localparam int CFG_IDX_BITS = 3;
    localparam int QUEUE_DEPTH  = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ZONE_MIN_X,
        CFG_ZONE_MAX_X,
        CFG_ZONE_MIN_Z,
        CFG_ZONE_MAX_Z,
        CFG_EXIT_MARGIN,
        CFG_ACQUIRE,
        CFG_GRACE,
        CFG_DROP
    } cfg_index_t;

    localparam int ZONE_MIN_X_RST  = -1000;
    localparam int ZONE_MAX_X_RST  = 1000;
    localparam int ZONE_MIN_Z_RST  = 1000;
    localparam int ZONE_MAX_Z_RST  = 3000;
    localparam int EXIT_MARGIN_RST = 300;
    localparam int ACQUIRE_RST     = 10;
    localparam int GRACE_RST       = 5;
    localparam int DROP_RST        = 30;

    // Per-slot classification produced by the front end.
    typedef struct packed {
        logic last;     // closes the frame
        logic active;   // slot holds a tracked body
        logic elig;     // may compete for candidate
        logic hold_ok;  // good enough to keep a locked target
    } slot_flags_t;

    localparam int FLAG_BITS = $bits(slot_flags_t);

    // Packed slot: flags, id, x, y, z, limbs (msb first).
    function automatic int body_bits(input int coord_bits);
        return FLAG_BITS + ID_BITS + 3 * coord_bits + LIMB_BITS;
    endfunction

    // Sum of two squared doubled offsets.
    function automatic int dist_bits(input int coord_bits);
        return 2 * (coord_bits + 1) + 1;
    endfunction

endpackage

// File: rtl/person_target_lock.sv
// Top level of the target lock block: config registers, front end, queue, back end.
// Depends on ptl_pkg, ptl_cfg, ptl_front, ptl_fifo and ptl_back.
//
//  channel | handshake             | beat
//  --------+-----------------------+----------------------------------------------
//  in      | in_valid / in_stall   | one body slot, last_slot closes the frame
//  out     | out_valid / out_stall | one result per frame
//  cfg     | cfg_wr_en             | cfg_index selects register, cfg_data value
//
// One slot per cycle while in_stall is low; the back end folds one slot each clock
// unless a closing slot waits on a stalled result. A closing slot reaches the result
// beat through the zone-compare stage and the square, sum, queue and back end registers.
// A stalled result holds the back end only on the next closing slot; the
// 4-entry queue and the front pipe keep taking slots until they fill.
// Reset clears the lock state and loads the default zone and counts.
module person_target_lock #(
    parameter int COORD_BITS = 16,
    parameter int COUNT_BITS = 10,
    localparam int CFG_BITS  = (COORD_BITS >= ptl_pkg::MARGIN_BITS) ?
                               ((COORD_BITS >= COUNT_BITS) ? COORD_BITS : COUNT_BITS) :
                               ((ptl_pkg::MARGIN_BITS >= COUNT_BITS) ?
                                ptl_pkg::MARGIN_BITS : COUNT_BITS)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [ptl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]               cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              slot_active,
    input  logic [ptl_pkg::ID_BITS-1:0]       body_id,
    input  logic                              core_ok,
    input  logic                              hip_finite,
    input  logic signed [COORD_BITS-1:0]      hip_x,
    input  logic signed [COORD_BITS-1:0]      hip_y,
    input  logic signed [COORD_BITS-1:0]      hip_z,
    input  logic [ptl_pkg::LIMB_BITS-1:0]     limb_mask,
    input  logic                              last_slot,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              person_tracked,
    output logic [ptl_pkg::ID_BITS-1:0]       locked_id,
    output logic signed [COORD_BITS-1:0]      out_hip_x,
    output logic signed [COORD_BITS-1:0]      out_hip_y,
    output logic signed [COORD_BITS-1:0]      out_hip_z,
    output logic [ptl_pkg::LIMB_BITS-1:0]     out_limbs,
    output logic [COUNT_BITS-1:0]             candidate_progress
);

    localparam int BODY_BITS = ptl_pkg::body_bits(COORD_BITS);
    localparam int DIST_BITS = ptl_pkg::dist_bits(COORD_BITS);
    localparam int Q_BITS    = BODY_BITS + DIST_BITS;

    logic signed [COORD_BITS-1:0]    zone_min_x, zone_max_x, zone_min_z, zone_max_z;
    logic [ptl_pkg::MARGIN_BITS-1:0] exit_margin;
    logic [COUNT_BITS-1:0]           acquire_count, grace_count, drop_count;

    logic                 q_push, q_ready, q_valid, q_pop;
    logic [BODY_BITS-1:0] f_body, b_body;
    logic [DIST_BITS-1:0] f_dist, b_dist;
    logic [Q_BITS-1:0]    q_out;

    ptl_cfg #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS),
        .CFG_BITS   (CFG_BITS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .zone_min_x    (zone_min_x),
        .zone_max_x    (zone_max_x),
        .zone_min_z    (zone_min_z),
        .zone_max_z    (zone_max_z),
        .exit_margin   (exit_margin),
        .acquire_count (acquire_count),
        .grace_count   (grace_count),
        .drop_count    (drop_count)
    );

    ptl_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .slot_active (slot_active),
        .body_id     (body_id),
        .core_ok     (core_ok),
        .hip_finite  (hip_finite),
        .hip_x       (hip_x),
        .hip_y       (hip_y),
        .hip_z       (hip_z),
        .limb_mask   (limb_mask),
        .last_slot   (last_slot),
        .zone_min_x  (zone_min_x),
        .zone_max_x  (zone_max_x),
        .zone_min_z  (zone_min_z),
        .zone_max_z  (zone_max_z),
        .exit_margin (exit_margin),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_body      (f_body),
        .q_dist      (f_dist)
    );

    ptl_fifo #(
        .WIDTH (Q_BITS)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_body, f_dist}),
        .ready     (q_ready),
        .valid     (q_valid),
        .pop       (q_pop),
        .pop_data  (q_out)
    );

    assign b_body = q_out[Q_BITS-1 -: BODY_BITS];
    assign b_dist = q_out[DIST_BITS-1:0];

    ptl_back #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_valid            (q_valid),
        .q_pop              (q_pop),
        .q_body             (b_body),
        .q_dist             (b_dist),
        .acquire_count      (acquire_count),
        .grace_count        (grace_count),
        .drop_count         (drop_count),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .person_tracked     (person_tracked),
        .locked_id          (locked_id),
        .out_hip_x          (out_hip_x),
        .out_hip_y          (out_hip_y),
        .out_hip_z          (out_hip_z),
        .out_limbs          (out_limbs),
        .candidate_progress (candidate_progress)
    );

endmodule

// File: rtl/ptl_cfg.sv
// Configuration register file for the target lock block.
// Depends on ptl_pkg for register indexes and reset values.
module ptl_cfg #(
    parameter int COORD_BITS = 16,
    parameter int COUNT_BITS = 10,
    parameter int CFG_BITS   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [ptl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [CFG_BITS-1:0]                  cfg_data,
    output logic signed [COORD_BITS-1:0]         zone_min_x,
    output logic signed [COORD_BITS-1:0]         zone_max_x,
    output logic signed [COORD_BITS-1:0]         zone_min_z,
    output logic signed [COORD_BITS-1:0]         zone_max_z,
    output logic [ptl_pkg::MARGIN_BITS-1:0]      exit_margin,
    output logic [COUNT_BITS-1:0]                acquire_count,
    output logic [COUNT_BITS-1:0]                grace_count,
    output logic [COUNT_BITS-1:0]                drop_count
);

    logic signed [COORD_BITS-1:0]    zone_min_x_reg;
    logic signed [COORD_BITS-1:0]    zone_max_x_reg;
    logic signed [COORD_BITS-1:0]    zone_min_z_reg;
    logic signed [COORD_BITS-1:0]    zone_max_z_reg;
    logic [ptl_pkg::MARGIN_BITS-1:0] exit_margin_reg;
    logic [COUNT_BITS-1:0]           acquire_reg;
    logic [COUNT_BITS-1:0]           grace_reg;
    logic [COUNT_BITS-1:0]           drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_min_x_reg  <= COORD_BITS'(ptl_pkg::ZONE_MIN_X_RST);
            zone_max_x_reg  <= COORD_BITS'(ptl_pkg::ZONE_MAX_X_RST);
            zone_min_z_reg  <= COORD_BITS'(ptl_pkg::ZONE_MIN_Z_RST);
            zone_max_z_reg  <= COORD_BITS'(ptl_pkg::ZONE_MAX_Z_RST);
            exit_margin_reg <= ptl_pkg::MARGIN_BITS'(ptl_pkg::EXIT_MARGIN_RST);
            acquire_reg     <= COUNT_BITS'(ptl_pkg::ACQUIRE_RST);
            grace_reg       <= COUNT_BITS'(ptl_pkg::GRACE_RST);
            drop_reg        <= COUNT_BITS'(ptl_pkg::DROP_RST);
        end
        else if (cfg_wr_en)
        begin
            unique case (ptl_pkg::cfg_index_t'(cfg_index))
                ptl_pkg::CFG_ZONE_MIN_X:  zone_min_x_reg  <= cfg_data[COORD_BITS-1:0];
                ptl_pkg::CFG_ZONE_MAX_X:  zone_max_x_reg  <= cfg_data[COORD_BITS-1:0];
                ptl_pkg::CFG_ZONE_MIN_Z:  zone_min_z_reg  <= cfg_data[COORD_BITS-1:0];
                ptl_pkg::CFG_ZONE_MAX_Z:  zone_max_z_reg  <= cfg_data[COORD_BITS-1:0];
                ptl_pkg::CFG_EXIT_MARGIN: exit_margin_reg <= cfg_data[ptl_pkg::MARGIN_BITS-1:0];
                ptl_pkg::CFG_ACQUIRE:     acquire_reg     <= cfg_data[COUNT_BITS-1:0];
                ptl_pkg::CFG_GRACE:       grace_reg       <= cfg_data[COUNT_BITS-1:0];
                ptl_pkg::CFG_DROP:        drop_reg        <= cfg_data[COUNT_BITS-1:0];
            endcase
        end
    end

    assign zone_min_x    = zone_min_x_reg;
    assign zone_max_x    = zone_max_x_reg;
    assign zone_min_z    = zone_min_z_reg;
    assign zone_max_z    = zone_max_z_reg;
    assign exit_margin   = exit_margin_reg;
    assign acquire_count = acquire_reg;
    assign grace_count   = grace_reg;
    assign drop_count    = drop_reg;

endmodule

// File: rtl/ptl_front.sv
// Front end: accepts body slots, classifies them against the zones and
// computes four times the squared x-z distance to the zone centre. Depends on ptl_pkg.
module ptl_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic                                       slot_active,
    input  logic [ptl_pkg::ID_BITS-1:0]                body_id,
    input  logic                                       core_ok,
    input  logic                                       hip_finite,
    input  logic signed [COORD_BITS-1:0]               hip_x,
    input  logic signed [COORD_BITS-1:0]               hip_y,
    input  logic signed [COORD_BITS-1:0]               hip_z,
    input  logic [ptl_pkg::LIMB_BITS-1:0]              limb_mask,
    input  logic                                       last_slot,
    input  logic signed [COORD_BITS-1:0]               zone_min_x,
    input  logic signed [COORD_BITS-1:0]               zone_max_x,
    input  logic signed [COORD_BITS-1:0]               zone_min_z,
    input  logic signed [COORD_BITS-1:0]               zone_max_z,
    input  logic [ptl_pkg::MARGIN_BITS-1:0]            exit_margin,
    input  logic                                       q_ready,
    output logic                                       q_push,
    output logic [ptl_pkg::body_bits(COORD_BITS)-1:0]  q_body,
    output logic [ptl_pkg::dist_bits(COORD_BITS)-1:0]  q_dist
);

    localparam int BODY_BITS = ptl_pkg::body_bits(COORD_BITS);
    localparam int DIST_BITS = ptl_pkg::dist_bits(COORD_BITS);
    localparam int DIFF_BITS = COORD_BITS + 2;
    localparam int SQ_BITS   = 2 * (COORD_BITS + 1);
    localparam int EXT_BITS  = ((COORD_BITS > ptl_pkg::MARGIN_BITS) ?
                                COORD_BITS : ptl_pkg::MARGIN_BITS) + 2;

    logic                         adv;
    ptl_pkg::slot_flags_t         flags_c;
    logic [BODY_BITS-1:0]         body_c;
    logic                         in_zone_c;
    logic                         in_exit_c;
    logic signed [EXT_BITS-1:0]   x_e, z_e, minx_e, maxx_e, minz_e, maxz_e, mg_e;
    logic signed [DIFF_BITS-1:0]  x_d, z_d, minx_d, maxx_d, minz_d, maxz_d;
    logic signed [DIFF_BITS-1:0]  dx_c, dz_c;
    logic signed [2*DIFF_BITS-1:0] sqx_full, sqz_full;

    logic                         s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [BODY_BITS-1:0]         s1_body_reg, s2_body_reg, s3_body_reg;
    logic signed [DIFF_BITS-1:0]  s1_dx_reg, s1_dz_reg;
    logic [SQ_BITS-1:0]           s2_sqx_reg, s2_sqz_reg;
    logic [DIST_BITS-1:0]         s3_dist_reg;

    // Whole pipe moves together; hold only when the queue cannot take stage 3.
    assign in_stall = s3_valid_reg && !q_ready;
    assign adv      = !in_stall;

    always_comb
    begin
        x_e    = {{(EXT_BITS-COORD_BITS){hip_x[COORD_BITS-1]}}, hip_x};
        z_e    = {{(EXT_BITS-COORD_BITS){hip_z[COORD_BITS-1]}}, hip_z};
        minx_e = {{(EXT_BITS-COORD_BITS){zone_min_x[COORD_BITS-1]}}, zone_min_x};
        maxx_e = {{(EXT_BITS-COORD_BITS){zone_max_x[COORD_BITS-1]}}, zone_max_x};
        minz_e = {{(EXT_BITS-COORD_BITS){zone_min_z[COORD_BITS-1]}}, zone_min_z};
        maxz_e = {{(EXT_BITS-COORD_BITS){zone_max_z[COORD_BITS-1]}}, zone_max_z};
        mg_e   = {{(EXT_BITS-ptl_pkg::MARGIN_BITS){1'b0}}, exit_margin};

        in_zone_c = (hip_x >= zone_min_x) && (hip_x <= zone_max_x) &&
                    (hip_z >= zone_min_z) && (hip_z <= zone_max_z);
        in_exit_c = (x_e >= minx_e - mg_e) && (x_e <= maxx_e + mg_e) &&
                    (z_e >= minz_e - mg_e) && (z_e <= maxz_e + mg_e);

        flags_c.last    = last_slot;
        flags_c.active  = slot_active;
        flags_c.elig    = slot_active && core_ok && hip_finite && in_zone_c;
        flags_c.hold_ok = core_ok && hip_finite && in_exit_c;

        body_c = {flags_c, body_id, hip_x, hip_y, hip_z, limb_mask};

        // Offsets from the doubled zone centre.
        x_d    = {{(DIFF_BITS-COORD_BITS){hip_x[COORD_BITS-1]}}, hip_x};
        z_d    = {{(DIFF_BITS-COORD_BITS){hip_z[COORD_BITS-1]}}, hip_z};
        minx_d = {{(DIFF_BITS-COORD_BITS){zone_min_x[COORD_BITS-1]}}, zone_min_x};
        maxx_d = {{(DIFF_BITS-COORD_BITS){zone_max_x[COORD_BITS-1]}}, zone_max_x};
        minz_d = {{(DIFF_BITS-COORD_BITS){zone_min_z[COORD_BITS-1]}}, zone_min_z};
        maxz_d = {{(DIFF_BITS-COORD_BITS){zone_max_z[COORD_BITS-1]}}, zone_max_z};
        dx_c   = (x_d <<< 1) - (minx_d + maxx_d);
        dz_c   = (z_d <<< 1) - (minz_d + maxz_d);

        sqx_full = s1_dx_reg * s1_dx_reg;
        sqz_full = s1_dz_reg * s1_dz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_body_reg <= body_c;
            s1_dx_reg   <= dx_c;
            s1_dz_reg   <= dz_c;
            s2_body_reg <= s1_body_reg;
            s2_sqx_reg  <= sqx_full[SQ_BITS-1:0];
            s2_sqz_reg  <= sqz_full[SQ_BITS-1:0];
            s3_body_reg <= s2_body_reg;
            s3_dist_reg <= {1'b0, s2_sqx_reg} + {1'b0, s2_sqz_reg};
        end
    end

    assign q_push = s3_valid_reg && q_ready;
    assign q_body = s3_body_reg;
    assign q_dist = s3_dist_reg;

endmodule

// File: rtl/ptl_fifo.sv
// Short queue between the front end and the back end.
// Depends on ptl_pkg for its depth.
module ptl_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             ready,
    output logic             valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH    = ptl_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign ready    = (count_reg != CNT_BITS'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: rtl/ptl_back.sv
// Back end: folds classified slots into the per-frame best and target match,
// updates the lock state at frame end and holds the result beat.
// Depends on ptl_pkg and person_target_lock_defines.svh.
`include "person_target_lock_defines.svh"

module ptl_back #(
    parameter int COORD_BITS = 16,
    parameter int COUNT_BITS = 10
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       q_valid,
    output logic                                       q_pop,
    input  logic [ptl_pkg::body_bits(COORD_BITS)-1:0]  q_body,
    input  logic [ptl_pkg::dist_bits(COORD_BITS)-1:0]  q_dist,
    input  logic [COUNT_BITS-1:0]                      acquire_count,
    input  logic [COUNT_BITS-1:0]                      grace_count,
    input  logic [COUNT_BITS-1:0]                      drop_count,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic                                       person_tracked,
    output logic [ptl_pkg::ID_BITS-1:0]                locked_id,
    output logic signed [COORD_BITS-1:0]               out_hip_x,
    output logic signed [COORD_BITS-1:0]               out_hip_y,
    output logic signed [COORD_BITS-1:0]               out_hip_z,
    output logic [ptl_pkg::LIMB_BITS-1:0]              out_limbs,
    output logic [COUNT_BITS-1:0]                      candidate_progress
);

    localparam int BODY_BITS = ptl_pkg::body_bits(COORD_BITS);
    localparam int DIST_BITS = ptl_pkg::dist_bits(COORD_BITS);
    localparam int LIMB_BITS = ptl_pkg::LIMB_BITS;
    localparam int ID_BITS   = ptl_pkg::ID_BITS;
    localparam int LOST_BITS = COUNT_BITS + 1;

    // Slot fields
    ptl_pkg::slot_flags_t         fl;
    logic [ID_BITS-1:0]           s_id;
    logic signed [COORD_BITS-1:0] s_x, s_y, s_z;
    logic [LIMB_BITS-1:0]         s_limbs;

    // Lock state
    logic [ID_BITS-1:0]           target_reg, target_next;
    logic [ID_BITS-1:0]           cand_reg, cand_next;
    logic [COUNT_BITS-1:0]        cand_frames_reg, cand_frames_next;
    logic [LOST_BITS-1:0]         lost_reg, lost_next;
    logic signed [COORD_BITS-1:0] hip_x_reg, hip_x_next;
    logic signed [COORD_BITS-1:0] hip_y_reg, hip_y_next;
    logic signed [COORD_BITS-1:0] hip_z_reg, hip_z_next;

    // Per-frame accumulation
    logic                         best_found_reg, best_found_next;
    logic [DIST_BITS-1:0]         best_dist_reg, best_dist_next;
    logic [ID_BITS-1:0]           best_id_reg, best_id_next;
    logic signed [COORD_BITS-1:0] best_x_reg, best_x_next;
    logic signed [COORD_BITS-1:0] best_y_reg, best_y_next;
    logic signed [COORD_BITS-1:0] best_z_reg, best_z_next;
    logic [LIMB_BITS-1:0]         best_limbs_reg, best_limbs_next;
    logic                         match_found_reg, match_found_next;
    logic                         match_ok_reg, match_ok_next;
    logic signed [COORD_BITS-1:0] match_x_reg, match_x_next;
    logic signed [COORD_BITS-1:0] match_y_reg, match_y_next;
    logic signed [COORD_BITS-1:0] match_z_reg, match_z_next;
    logic [LIMB_BITS-1:0]         match_limbs_reg, match_limbs_next;

    // Result beat
    logic                         out_valid_reg, out_valid_next;
    logic                         out_tracked_reg, out_tracked_next;
    logic [LIMB_BITS-1:0]         out_limbs_reg, out_limbs_next;

    // Frame view including the current slot
    logic                         take, frame_end, better, hit;
    logic                         nb_found, nm_found, nm_ok;
    logic [DIST_BITS-1:0]         nb_dist;
    logic [ID_BITS-1:0]           nb_id;
    logic signed [COORD_BITS-1:0] nb_x, nb_y, nb_z, nm_x, nm_y, nm_z;
    logic [LIMB_BITS-1:0]         nb_limbs, nm_limbs;
    logic [COUNT_BITS-1:0]        frames_inc;
    logic [LOST_BITS-1:0]         lost_inc;

    assign fl      = ptl_pkg::slot_flags_t'(q_body[BODY_BITS-1 -: ptl_pkg::FLAG_BITS]);
    assign s_id    = q_body[LIMB_BITS + 3*COORD_BITS +: ID_BITS];
    assign s_x     = q_body[LIMB_BITS + 2*COORD_BITS +: COORD_BITS];
    assign s_y     = q_body[LIMB_BITS + COORD_BITS +: COORD_BITS];
    assign s_z     = q_body[LIMB_BITS +: COORD_BITS];
    assign s_limbs = q_body[0 +: LIMB_BITS];

    // Only the frame-closing beat needs room in the output register.
    assign take      = q_valid && (!fl.last || !out_valid_reg || !out_stall);
    assign frame_end = take && fl.last;
    assign q_pop     = take;

    always_comb
    begin
        better   = fl.elig && (!best_found_reg || (q_dist < best_dist_reg));
        nb_found = best_found_reg || better;
        nb_dist  = better ? q_dist  : best_dist_reg;
        nb_id    = better ? s_id    : best_id_reg;
        nb_x     = better ? s_x     : best_x_reg;
        nb_y     = better ? s_y     : best_y_reg;
        nb_z     = better ? s_z     : best_z_reg;
        nb_limbs = better ? s_limbs : best_limbs_reg;

        hit      = (target_reg != '0) && fl.active && !match_found_reg && (s_id == target_reg);
        nm_found = match_found_reg || hit;
        nm_ok    = hit ? fl.hold_ok : match_ok_reg;
        nm_x     = hit ? s_x     : match_x_reg;
        nm_y     = hit ? s_y     : match_y_reg;
        nm_z     = hit ? s_z     : match_z_reg;
        nm_limbs = hit ? s_limbs : match_limbs_reg;

        frames_inc = (cand_frames_reg == '1) ? cand_frames_reg : cand_frames_reg + 1'b1;
        lost_inc   = (lost_reg == '1) ? lost_reg : lost_reg + 1'b1;

        target_next      = target_reg;
        cand_next        = cand_reg;
        cand_frames_next = cand_frames_reg;
        lost_next        = lost_reg;
        hip_x_next       = hip_x_reg;
        hip_y_next       = hip_y_reg;
        hip_z_next       = hip_z_reg;

        best_found_next  = best_found_reg;
        best_dist_next   = best_dist_reg;
        best_id_next     = best_id_reg;
        best_x_next      = best_x_reg;
        best_y_next      = best_y_reg;
        best_z_next      = best_z_reg;
        best_limbs_next  = best_limbs_reg;
        match_found_next = match_found_reg;
        match_ok_next    = match_ok_reg;
        match_x_next     = match_x_reg;
        match_y_next     = match_y_reg;
        match_z_next     = match_z_reg;
        match_limbs_next = match_limbs_reg;

        out_valid_next   = out_valid_reg && out_stall;
        out_tracked_next = out_tracked_reg;
        out_limbs_next   = out_limbs_reg;

        if (take && !fl.last)
        begin
            best_found_next  = nb_found;
            best_dist_next   = nb_dist;
            best_id_next     = nb_id;
            best_x_next      = nb_x;
            best_y_next      = nb_y;
            best_z_next      = nb_z;
            best_limbs_next  = nb_limbs;
            match_found_next = nm_found;
            match_ok_next    = nm_ok;
            match_x_next     = nm_x;
            match_y_next     = nm_y;
            match_z_next     = nm_z;
            match_limbs_next = nm_limbs;
        end
        else if (frame_end)
        begin
            best_found_next  = 1'b0;
            best_dist_next   = '0;
            match_found_next = 1'b0;
            out_valid_next   = 1'b1;
            out_tracked_next = 1'b0;
            out_limbs_next   = '0;

            if (target_reg == '0)
            begin
                priority if (!nb_found)
                begin
                    cand_next        = '0;
                    cand_frames_next = '0;
                end
                else if (cand_reg != nb_id)
                begin
                    cand_next        = nb_id;
                    cand_frames_next = COUNT_BITS'(1);
                end
                else if (frames_inc >= acquire_count)
                begin
                    // Lock; a zero identity leaves the search running.
                    target_next      = nb_id;
                    lost_next        = '0;
                    cand_next        = '0;
                    cand_frames_next = '0;
                    hip_x_next       = nb_x;
                    hip_y_next       = nb_y;
                    hip_z_next       = nb_z;
                    out_limbs_next   = nb_limbs;
                    out_tracked_next = 1'b1;
                end
                else
                begin
                    cand_frames_next = frames_inc;
                end
            end
            else if (nm_found && nm_ok)
            begin
                lost_next        = '0;
                hip_x_next       = nm_x;
                hip_y_next       = nm_y;
                hip_z_next       = nm_z;
                out_limbs_next   = nm_limbs;
                out_tracked_next = 1'b1;
            end
            else if (lost_inc > {1'b0, drop_count})
            begin
                // Drop the target and forget its position.
                target_next      = '0;
                lost_next        = '0;
                cand_next        = '0;
                cand_frames_next = '0;
                hip_x_next       = '0;
                hip_y_next       = '0;
                hip_z_next       = '0;
            end
            else
            begin
                lost_next        = lost_inc;
                out_tracked_next = (lost_inc <= {1'b0, grace_count});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg      <= '0;
            cand_reg        <= '0;
            cand_frames_reg <= '0;
            lost_reg        <= '0;
            hip_x_reg       <= '0;
            hip_y_reg       <= '0;
            hip_z_reg       <= '0;
            best_found_reg  <= 1'b0;
            best_dist_reg   <= '0;
            match_found_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            target_reg      <= target_next;
            cand_reg        <= cand_next;
            cand_frames_reg <= cand_frames_next;
            lost_reg        <= lost_next;
            hip_x_reg       <= hip_x_next;
            hip_y_reg       <= hip_y_next;
            hip_z_reg       <= hip_z_next;
            best_found_reg  <= best_found_next;
            best_dist_reg   <= best_dist_next;
            match_found_reg <= match_found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_id_reg     <= best_id_next;
        best_x_reg      <= best_x_next;
        best_y_reg      <= best_y_next;
        best_z_reg      <= best_z_next;
        best_limbs_reg  <= best_limbs_next;
        match_ok_reg    <= match_ok_next;
        match_x_reg     <= match_x_next;
        match_y_reg     <= match_y_next;
        match_z_reg     <= match_z_next;
        match_limbs_reg <= match_limbs_next;
        out_tracked_reg <= out_tracked_next;
        out_limbs_reg   <= out_limbs_next;
    end

    assign out_valid          = out_valid_reg;
    assign person_tracked     = out_tracked_reg;
    assign locked_id          = target_reg;
    assign out_hip_x          = hip_x_reg;
    assign out_hip_y          = hip_y_reg;
    assign out_hip_z          = hip_z_reg;
    assign out_limbs          = out_limbs_reg;
    assign candidate_progress = cand_frames_reg;

    `PTL_ASSERT_IMP(a_lock_clears_cand, clk, rst_n, target_reg != '0,
        cand_reg == '0 && cand_frames_reg == '0, "candidate kept while locked")
    `PTL_ASSERT_IMP(a_lost_needs_target, clk, rst_n, lost_reg != '0,
        target_reg != '0, "lost count without a target")
    `PTL_ASSERT_IMP(a_match_needs_target, clk, rst_n, match_found_reg,
        target_reg != '0, "target match recorded with no target")
    `PTL_ASSERT_IMP(a_limbs_imply_tracked, clk, rst_n, out_valid_reg && out_limbs_reg != '0,
        out_tracked_reg, "limb flags on an untracked result")
    `PTL_ASSERT_NXT(a_frame_end_beat, clk, rst_n, frame_end,
        out_valid_reg, "frame closed without a result beat")

endmodule
